@@ hdl/vector3_normalize_core_macros.svh @@
// ---------------------------------------------------------------------------
// vector3_normalize_core assertion macros
// Shorthands for clocked assertions on clk_i, with and without reset masking.
// ---------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_CORE_MACROS_SVH
`define VECTOR3_NORMALIZE_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define VN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define VN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/vn_pkg.sv @@
// ---------------------------------------------------------------------------
// vn_pkg
// Widths, types and constants shared by the vector normalisation pipeline.
// ---------------------------------------------------------------------------
package vn_pkg;

  localparam int IN_W      = 32;
  localparam int FRAC_BITS = 30;
  localparam int OUT_W     = 32;

  // Squares and their sum.
  localparam int S_W   = 2 * IN_W;
  localparam int REM_W = S_W + 1;
  // Quotient of c^2 * 2^(2F+2) / S, at most 2^(2F+2).
  localparam int Q_W   = 2 * FRAC_BITS + 3;
  // Square root of the quotient and its radicand.
  localparam int RT_W  = FRAC_BITS + 2;
  localparam int RAD_W = 2 * RT_W;
  localparam int SR_W  = RT_W + 1;

  localparam logic signed [OUT_W-1:0] UNIT_ONE = OUT_W'(1) << FRAC_BITS;

  typedef logic [IN_W-1:0]  mag_t;
  typedef logic [S_W-1:0]   sum_t;
  typedef logic [Q_W-1:0]   quo_t;
  typedef logic [RT_W-1:0]  root_t;
  typedef logic [RAD_W-1:0] rad_t;
  typedef logic [SR_W-1:0]  srem_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;

endpackage

@@ hdl/vn_front.sv @@
// ---------------------------------------------------------------------------
// vn_front
// Magnitudes, squares and the exact squared norm, three register stages.
// ---------------------------------------------------------------------------
module vn_front import vn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [3*IN_W-1:0] data_i,
  output logic              valid_o,
  output side_t             side_o,
  output sum_t [2:0]        sq_o,
  output sum_t              s_o
);

  logic         v1_q, v2_q, v3_q;
  side_t        side1_d, side1_q, side2_q, side3_q;
  mag_t [2:0]   mag1_d, mag1_q;
  sum_t [2:0]   sq2_q, sq3_q;
  sum_t         s3_q;

  always_comb begin
    side1_d.zero = (data_i == '0);
    for (int l = 0; l < 3; l++) begin
      side1_d.neg[l] = data_i[l*IN_W + IN_W - 1];
      mag1_d[l] = side1_d.neg[l] ? (~data_i[l*IN_W +: IN_W] + IN_W'(1))
                                 : data_i[l*IN_W +: IN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      mag1_q  <= mag1_d;
      side2_q <= side1_q;
      for (int l = 0; l < 3; l++) begin
        sq2_q[l] <= S_W'(mag1_q[l]) * S_W'(mag1_q[l]);
      end
      side3_q <= side2_q;
      sq3_q   <= sq2_q;
      s3_q    <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side3_q;
  assign sq_o    = sq3_q;
  assign s_o     = s3_q;

endmodule

@@ hdl/vn_div.sv @@
// ---------------------------------------------------------------------------
// vn_div
// Pipelined restoring divider, one quotient bit per stage for three lanes.
// ---------------------------------------------------------------------------
module vn_div import vn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  side_t      side_i,
  input  sum_t [2:0] sq_i,
  input  sum_t       s_i,
  output logic       valid_o,
  output side_t      side_o,
  output quo_t [2:0] quo_o
);

  logic       v_q    [Q_W];
  side_t      side_q [Q_W];
  sum_t       s_q    [Q_W];
  sum_t [2:0] rem_q  [Q_W];
  quo_t [2:0] quo_q  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic       v_in;
    side_t      side_in;
    sum_t       s_in;
    sum_t [2:0] rem_in, rem_d;
    quo_t [2:0] quo_in, quo_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign s_in    = s_i;
      assign rem_in  = sq_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign s_in    = s_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [REM_W-1:0] trial, diff;
      logic             take;
      // The first stage yields the integer bit; the square never exceeds the sum.
      assign trial = (k == 0) ? {1'b0, rem_in[l]} : {rem_in[l], 1'b0};
      assign diff  = trial - {1'b0, s_in};
      assign take  = (trial >= {1'b0, s_in});
      assign rem_d[l] = take ? diff[S_W-1:0] : trial[S_W-1:0];
      assign quo_d[l] = {quo_in[l][Q_W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        s_q[k]    <= s_in;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];

endmodule

@@ hdl/vn_sqrt.sv @@
// ---------------------------------------------------------------------------
// vn_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module vn_sqrt import vn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  side_t       side_i,
  input  quo_t [2:0]  quo_i,
  output logic        valid_o,
  output side_t       side_o,
  output root_t [2:0] root_o
);

  logic        v_q    [RT_W];
  side_t       side_q [RT_W];
  rad_t [2:0]  rad_q  [RT_W];
  srem_t [2:0] rem_q  [RT_W];
  root_t [2:0] root_q [RT_W];

  for (genvar j = 0; j < RT_W; j++) begin : g_stage
    logic        v_in;
    side_t       side_in;
    rad_t [2:0]  rad_in, rad_d;
    srem_t [2:0] rem_in, rem_d;
    root_t [2:0] root_in, root_d;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      for (genvar l = 0; l < 3; l++) begin : g_pad
        assign rad_in[l] = RAD_W'(quo_i[l]);
      end
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign side_in = side_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [SR_W+1:0] cur, trial, diff;
      logic            take;
      assign cur   = {rem_in[l], rad_in[l][RAD_W-1:RAD_W-2]};
      assign trial = (SR_W+2)'({root_in[l], 2'b01});
      assign diff  = cur - trial;
      assign take  = (cur >= trial);
      assign rem_d[l]  = take ? diff[SR_W-1:0] : cur[SR_W-1:0];
      assign root_d[l] = {root_in[l][RT_W-2:0], take};
      assign rad_d[l]  = {rad_in[l][RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= side_in;
        rad_q[j]  <= rad_d;
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
      end
    end
  end

  assign valid_o = v_q[RT_W-1];
  assign side_o  = side_q[RT_W-1];
  assign root_o  = root_q[RT_W-1];

endmodule

@@ hdl/vn_out.sv @@
// ---------------------------------------------------------------------------
// vn_out
// Rounding, sign and zero handling, and a two-entry output buffer.
// ---------------------------------------------------------------------------
module vn_out import vn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  side_t              side_i,
  input  root_t [2:0]        root_i,
  output logic               en_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [3*OUT_W-1:0] m_tdata_o,
  output logic               m_tuser_o
);

  logic [3*OUT_W-1:0] data_d;
  logic [3*OUT_W-1:0] buf_data_q [2];
  logic               buf_zero_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         cnt_d, cnt_q;
  logic               push, pop;

  // The root is twice the scaled magnitude; halving it with a carry-in of one
  // rounds to nearest, ties away from zero.
  always_comb begin
    logic [RT_W:0]    inc;
    root_t            mag;
    logic [OUT_W-1:0] ext;
    for (int l = 0; l < 3; l++) begin
      inc = {1'b0, root_i[l]} + (RT_W+1)'(1);
      mag = inc[RT_W:1];
      if (mag > (root_t'(1) << FRAC_BITS)) begin
        mag = root_t'(1) << FRAC_BITS;
      end
      ext = OUT_W'(mag);
      if (side_i.zero) begin
        data_d[l*OUT_W +: OUT_W] = '0;
      end else begin
        data_d[l*OUT_W +: OUT_W] = side_i.neg[l] ? (~ext + OUT_W'(1)) : ext;
      end
    end
  end

  assign pop  = m_tvalid_o && m_tready_i;
  assign en_o = (cnt_q != 2'd2) || m_tready_i;
  assign push = en_o && valid_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_data_q[wr_q] <= data_d;
      buf_zero_q[wr_q] <= side_i.zero;
    end
  end

  assign m_tvalid_o = (cnt_q != 2'd0);
  assign m_tdata_o  = buf_data_q[rd_q];
  assign m_tuser_o  = buf_zero_q[rd_q];

endmodule

@@ hdl/vector3_normalize_core.sv @@
// ---------------------------------------------------------------------------
// vector3_normalize_core
// Scales a signed integer 3-vector to unit length in signed Q1.30.
// ---------------------------------------------------------------------------
// Channel  Direction  Beat contents
// s_axis   in         x, y, z components, 32 bits signed each
// m_axis   out        unit x, y, z in Q1.30 (tdata), zero-vector flag (tuser)
//
// One beat enters per cycle while the pipeline is not held. There are 3 front
// stages, 63 divider stages and 32 square-root stages, plus the output buffer.
// The depth is set by one quotient bit per divider stage and one root bit per
// square-root stage. Reset clears the valid bits and the output buffer only.
// The whole pipeline holds when the two-entry output buffer is full and
// m_axis_tready_i is low; s_axis_tready_o then drops.
// ---------------------------------------------------------------------------
module vector3_normalize_core import vn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // x_component [31:0], y_component [63:32], z_component [95:64]
  input  logic [3*IN_W-1:0]  s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // unit_x [31:0], unit_y [63:32], unit_z [95:64]
  output logic [3*OUT_W-1:0] m_axis_tdata_o,
  // zero_vector [0]
  output logic               m_axis_tuser_o
);

  logic        en;
  logic        fr_valid, dv_valid, sq_valid;
  side_t       fr_side, dv_side, sq_side;
  sum_t [2:0]  fr_sq;
  sum_t        fr_s;
  quo_t [2:0]  dv_quo;
  root_t [2:0] sq_root;

  assign s_axis_tready_o = en;

  vn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .data_i  (s_axis_tdata_i),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .sq_o    (fr_sq),
    .s_o     (fr_s)
  );

  vn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .sq_i    (fr_sq),
    .s_i     (fr_s),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_o   (dv_quo)
  );

  vn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .side_i  (dv_side),
    .quo_i   (dv_quo),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  vn_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (sq_valid),
    .side_i     (sq_side),
    .root_i     (sq_root),
    .en_o       (en),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

@@ hdl/vn_checker.sv @@
// ---------------------------------------------------------------------------
// vn_checker
// Port-level checks on the vector normalisation core, bound to the top level.
// ---------------------------------------------------------------------------
`include "vector3_normalize_core_macros.svh"

module vn_checker import vn_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic [3*IN_W-1:0]  s_axis_tdata_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [3*OUT_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tuser_o
);

  logic signed [OUT_W-1:0] ux, uy, uz;

  assign ux = m_axis_tdata_o[OUT_W-1:0];
  assign uy = m_axis_tdata_o[2*OUT_W-1:OUT_W];
  assign uz = m_axis_tdata_o[3*OUT_W-1:2*OUT_W];

  // Input back-pressure only ever comes from a result waiting downstream.
  `VN_ASSERT(a_stall_needs_result, !s_axis_tready_o |-> m_axis_tvalid_o, "stall without result")
  `VN_ASSERT(a_zero_is_clean, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0, "zero vector with data")
  `VN_ASSERT(a_unit_range, m_axis_tvalid_o |-> ux <= UNIT_ONE && ux >= -UNIT_ONE && uy <= UNIT_ONE && uy >= -UNIT_ONE && uz <= UNIT_ONE && uz >= -UNIT_ONE, "component beyond unit")
  `VN_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled beat changed")
  // The buffer count is only known once a reset edge has been seen.
  `VN_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "output valid in reset")

endmodule

bind vector3_normalize_core vn_checker u_checker (.*);
